>>> rtl/core/blist_pkg.sv
// Package of shared types, constants and helper functions for the bounded list engine.
`timescale 1ns / 1ps

package blist_pkg;

   localparam int CAPACITY   = 32;
   localparam int DATA_WIDTH = 32;
   localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int ITEM_W     = 32;
   localparam int REMOVED_W  = 6;

   typedef enum logic [1:0] {
      MODE_INS_FRONT = 2'd0,
      MODE_INS_BACK  = 2'd1,
      MODE_DELETE    = 2'd2,
      MODE_LIST      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DELETE,
      S_LIST,
      S_SINGLE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic del_step;
      logic del_commit;
      logic list_step;
      logic load_single;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     empty;
      logic     walk_done;
      logic     out_free;
   } stat_type;

   // Position of the entry at a given offset from the front, wrapped once.
   function automatic logic [PTR_W-1:0] slot_f(input logic [PTR_W-1:0] front,
                                              input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - PTR_W){1'b0}}, front} + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

   // Position one step before the front, wrapping at zero.
   function automatic logic [PTR_W-1:0] prev_f(input logic [PTR_W-1:0] front);
      logic [PTR_W-1:0] p;
      if (front == '0) begin
         p = PTR_W'(CAPACITY - 1);
      end else begin
         p = front - 1'b1;
      end
      return p;
   endfunction

endpackage

>>> rtl/core/blist_ctrl.sv
// Controller state machine that sequences each request of the bounded list engine.
`timescale 1ns / 1ps

module blist_ctrl
   import blist_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.mode == MODE_DELETE && !stat.empty) begin
               state_in = S_DELETE;
            end else if (stat.mode == MODE_LIST && !stat.empty) begin
               state_in = S_LIST;
            end else begin
               state_in = S_SINGLE;
            end
         end
         S_DELETE: begin
            if (stat.walk_done) begin
               state_in = S_SINGLE;
            end
         end
         S_LIST: begin
            if (stat.walk_done) begin
               state_in = S_IDLE;
            end
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_DELETE: begin
            cmd.del_step   = 1'b1;
            cmd.del_commit = stat.walk_done;
         end
         S_LIST: begin
            cmd.list_step = 1'b1;
         end
         S_SINGLE: begin
            cmd.load_single = stat.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> rtl/core/blist_dp.sv
// Datapath of the bounded list engine: entry store, pointers, walk counters and result register.
`timescale 1ns / 1ps

module blist_dp
   import blist_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [1:0]               req_mode,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ITEM_W-1:0] rsp_item_value,
   output logic                     rsp_is_last,
   output logic [REMOVED_W-1:0]     rsp_removed_count,
   output logic [1:0]               rsp_status
);

   logic signed [DATA_WIDTH-1:0] mem [CAPACITY];

   mode_type                     mode_ff;
   logic signed [DATA_WIDTH-1:0] value_ff;
   logic [PTR_W-1:0]             front_ff, front_in;
   logic [CNT_W-1:0]             length_ff, length_in;
   logic [CNT_W-1:0]             rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]             kept_ff, kept_in;
   logic                         pend_ff, pend_in;
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   status_type                   sgl_status_ff, sgl_status_in;
   logic [REMOVED_W-1:0]         sgl_removed_ff, sgl_removed_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [ITEM_W-1:0]     item_ff, item_in;
   logic                         last_ff, last_in;
   logic [REMOVED_W-1:0]         removed_ff, removed_in;
   status_type                   status_ff, status_in;

   logic                         empty, full, out_free, walk_done;
   logic                         advance, issue, keep, load_list;
   logic                         wr_en;
   logic [PTR_W-1:0]             wr_addr, rd_addr;
   logic signed [DATA_WIDTH-1:0] wr_data;

   assign empty     = (length_ff == '0);
   assign full      = (length_ff == CNT_W'(CAPACITY));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign walk_done = (rd_cnt_ff == length_ff) && !pend_ff;

   // A listing walk holds its read-ahead entry while the result register is blocked.
   assign advance   = cmd.del_step || (cmd.list_step && (!pend_ff || out_free));
   assign issue     = advance && (rd_cnt_ff != length_ff);
   assign keep      = cmd.del_step && pend_ff && (rd_data_ff != value_ff);
   assign load_list = cmd.list_step && pend_ff && out_free;
   assign rd_addr   = slot_f(front_ff, rd_cnt_ff);

   assign stat.mode      = mode_ff;
   assign stat.empty     = empty;
   assign stat.walk_done = walk_done;
   assign stat.out_free  = out_free;

   always_comb begin
      front_in       = front_ff;
      length_in      = length_ff;
      rd_cnt_in      = rd_cnt_ff;
      kept_in        = kept_ff;
      pend_in        = pend_ff;
      sgl_status_in  = sgl_status_ff;
      sgl_removed_in = sgl_removed_ff;
      wr_en          = 1'b0;
      wr_addr        = slot_f(front_ff, kept_ff);
      wr_data        = rd_data_ff;

      if (cmd.capture) begin
         rd_cnt_in = '0;
         kept_in   = '0;
         pend_in   = 1'b0;
      end

      if (cmd.exec) begin
         sgl_removed_in = '0;
         if (mode_ff == MODE_INS_FRONT || mode_ff == MODE_INS_BACK) begin
            if (full) begin
               sgl_status_in = ST_FULL;
            end else begin
               sgl_status_in = ST_OK;
               wr_en         = 1'b1;
               wr_data       = value_ff;
               length_in     = length_ff + 1'b1;
               if (mode_ff == MODE_INS_FRONT) begin
                  front_in = prev_f(front_ff);
                  wr_addr  = prev_f(front_ff);
               end else begin
                  wr_addr = slot_f(front_ff, length_ff);
               end
            end
         end else begin
            sgl_status_in = empty ? ST_EMPTY : ST_OK;
         end
      end

      if (advance) begin
         pend_in = issue;
         if (issue) begin
            rd_cnt_in = rd_cnt_ff + 1'b1;
         end
      end

      // Survivors are packed toward the front; the write slot never passes the read slot.
      if (keep) begin
         wr_en   = 1'b1;
         kept_in = kept_ff + 1'b1;
      end

      if (cmd.del_commit) begin
         length_in      = kept_ff;
         sgl_removed_in = REMOVED_W'(length_ff - kept_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      item_in      = item_ff;
      last_in      = last_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_single) begin
         rsp_valid_in = 1'b1;
         item_in      = '0;
         last_in      = 1'b1;
         removed_in   = sgl_removed_ff;
         status_in    = sgl_status_ff;
      end else if (load_list) begin
         rsp_valid_in = 1'b1;
         item_in      = ITEM_W'(rd_data_ff);
         last_in      = (rd_cnt_ff == length_ff);
         removed_in   = '0;
         status_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= DATA_WIDTH'(req_value);
      end
      sgl_status_ff  <= sgl_status_in;
      sgl_removed_ff <= sgl_removed_in;
      item_ff        <= item_in;
      last_ff        <= last_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         length_ff    <= '0;
         rd_cnt_ff    <= '0;
         kept_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         length_ff    <= length_in;
         rd_cnt_ff    <= rd_cnt_in;
         kept_ff      <= kept_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_value    = item_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_status        = status_ff;

endmodule

>>> rtl/core/bounded_list_engine_unit.sv
// Top level of the bounded list engine: controller and datapath joined by command and status.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to 32 signed 32-bit values in a circular
// store with one write and one registered read per cycle, and works on one request
// at a time. A request that returns a single status (an insert at the front or back,
// or a delete or list on an empty list) passes through the execute state and then
// loads its result into the result register from the single-result state once that
// register is free, after which the next request can be taken; an insert into a full
// list drops its value and reports status full. A delete walks the store once, one
// entry per cycle, then loads its one result with the number of entries removed from
// the single-result state and returns to idle, so a delete on a full list is the
// longest request while results are not stalled. A list streams one result per cycle
// front to back while the result channel is not stalled, with is_last on the final
// entry; the next request can be taken once the walk is done. A result waits in the
// result register while it is stalled, and a listing walk pauses with it. Delete and
// list on an empty list return a single result with status empty. The result
// register lets a finished result wait while the next request is taken.
module bounded_list_engine_unit
   import blist_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ITEM_W-1:0] rsp_item_value,
   output logic                     rsp_is_last,
   output logic [REMOVED_W-1:0]     rsp_removed_count,
   output logic [1:0]               rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   blist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   blist_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_value    (rsp_item_value),
      .rsp_is_last       (rsp_is_last),
      .rsp_removed_count (rsp_removed_count),
      .rsp_status        (rsp_status)
   );

endmodule

>>> tb/tb_bounded_list_engine_unit.sv
// Self-checking testbench for the bounded list engine: directed table, random requests, predictor.
`timescale 1ns / 1ps

module tb_bounded_list_engine_unit;
   import blist_pkg::*;

   localparam int DIRECTED_ROWS = 23;
   localparam int LIMIT_CYCLES  = 600000;
   localparam int PHASE_ITEMS   = 100;
   localparam int TAIL_CYCLES   = 40;

   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   typedef struct packed {
      logic signed [ITEM_W-1:0] item;
      logic                     last;
      logic [REMOVED_W-1:0]     removed;
      status_type               status;
   } list_result_type;

   typedef struct packed {
      mode_type             mode;
      logic signed [31:0]   value;
      logic                 typed;
      status_type           status;
      logic [REMOVED_W-1:0] removed;
   } directed_row_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_mode = '0;
   logic signed [31:0]       req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [ITEM_W-1:0] rsp_item_value;
   logic                     rsp_is_last;
   logic [REMOVED_W-1:0]     rsp_removed_count;
   logic [1:0]               rsp_status;

   // Shadow copy of the list held by the block.
   logic signed [DATA_WIDTH-1:0] model_store [CAPACITY];
   int model_front = 0;
   int model_len   = 0;

   list_result_type op_results[$];
   list_result_type awaited_results[$];

   int idle_phase     = IDLE_NONE;
   int sent_count     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{MODE_LIST,      32'sh0000_0000, 1'b1, ST_EMPTY, 6'd0},
      '{MODE_DELETE,    32'sh0000_0000, 1'b1, ST_EMPTY, 6'd0},
      '{MODE_INS_FRONT, 32'sh7FFF_FFFF, 1'b1, ST_OK,    6'd0},
      '{MODE_INS_BACK,  32'sh8000_0000, 1'b1, ST_OK,    6'd0},
      '{MODE_INS_FRONT, 32'sh0000_0000, 1'b1, ST_OK,    6'd0},
      '{MODE_INS_BACK,  32'shFFFF_FFFF, 1'b1, ST_OK,    6'd0},
      '{MODE_INS_BACK,  32'sh5555_5555, 1'b1, ST_OK,    6'd0},
      '{MODE_INS_FRONT, 32'shAAAA_AAAA, 1'b1, ST_OK,    6'd0},
      '{MODE_LIST,      32'sh0000_0000, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'sh0000_3039, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'shAAAA_AAAA, 1'b0, ST_OK,    6'd0},
      '{MODE_INS_BACK,  32'sh0000_0000, 1'b1, ST_OK,    6'd0},
      '{MODE_LIST,      32'shFFFF_FFFF, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'sh0000_0000, 1'b0, ST_OK,    6'd0},
      '{MODE_LIST,      32'sh0000_0000, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'sh7FFF_FFFF, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'sh8000_0000, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'shFFFF_FFFF, 1'b0, ST_OK,    6'd0},
      '{MODE_DELETE,    32'sh5555_5555, 1'b0, ST_OK,    6'd0},
      '{MODE_LIST,      32'sh0000_0000, 1'b1, ST_EMPTY, 6'd0},
      '{MODE_DELETE,    32'sh0000_0001, 1'b1, ST_EMPTY, 6'd0},
      '{MODE_INS_BACK,  32'sh0000_0003, 1'b1, ST_OK,    6'd0},
      '{MODE_DELETE,    32'sh0000_0003, 1'b1, ST_OK,    6'd1}
   };

   bounded_list_engine_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_value    (rsp_item_value),
      .rsp_is_last       (rsp_is_last),
      .rsp_removed_count (rsp_removed_count),
      .rsp_status        (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void push_op_result(input logic signed [ITEM_W-1:0] item,
                                          input logic last,
                                          input logic [REMOVED_W-1:0] removed,
                                          input status_type status);
      list_result_type r;
      r.item    = item;
      r.last    = last;
      r.removed = removed;
      r.status  = status;
      op_results.push_back(r);
   endfunction

   // Applies one request to the shadow list and leaves its results in op_results.
   function automatic void apply_list_op(input mode_type m, input logic signed [31:0] v);
      logic signed [DATA_WIDTH-1:0] key;
      logic signed [DATA_WIDTH-1:0] e;
      int kept;
      op_results.delete();
      key = v[DATA_WIDTH-1:0];
      case (m)
         MODE_INS_FRONT, MODE_INS_BACK: begin
            if (model_len >= CAPACITY) begin
               push_op_result('0, 1'b1, '0, ST_FULL);
            end else begin
               if (m == MODE_INS_FRONT) begin
                  model_front = (model_front + CAPACITY - 1) % CAPACITY;
                  model_store[model_front] = key;
               end else begin
                  model_store[(model_front + model_len) % CAPACITY] = key;
               end
               model_len++;
               push_op_result('0, 1'b1, '0, ST_OK);
            end
         end
         MODE_DELETE: begin
            if (model_len == 0) begin
               push_op_result('0, 1'b1, '0, ST_EMPTY);
            end else begin
               kept = 0;
               for (int i = 0; i < model_len; i++) begin
                  e = model_store[(model_front + i) % CAPACITY];
                  if (e != key) begin
                     model_store[(model_front + kept) % CAPACITY] = e;
                     kept++;
                  end
               end
               push_op_result('0, 1'b1, REMOVED_W'(model_len - kept), ST_OK);
               model_len = kept;
            end
         end
         default: begin
            if (model_len == 0) begin
               push_op_result('0, 1'b1, '0, ST_EMPTY);
            end else begin
               for (int i = 0; i < model_len; i++) begin
                  e = model_store[(model_front + i) % CAPACITY];
                  push_op_result(ITEM_W'(e), (i + 1 == model_len), '0, ST_OK);
               end
            end
         end
      endcase
   endfunction

   // Presents one request and waits for it to be taken. A typed row replaces the
   // predicted result with the single result written in the table.
   task automatic send_request(input mode_type m, input logic signed [31:0] v,
                               input logic typed, input status_type want_status,
                               input logic [REMOVED_W-1:0] want_removed);
      int gap_pct;
      list_result_type fixed_result;
      gap_pct = (idle_phase == IDLE_SENDER) ? 64 : (idle_phase == IDLE_BOTH) ? 26 : 0;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= m;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_list_op(m, v);
      if (typed) begin
         fixed_result.item    = '0;
         fixed_result.last    = 1'b1;
         fixed_result.removed = want_removed;
         fixed_result.status  = want_status;
         awaited_results.push_back(fixed_result);
      end else begin
         foreach (op_results[k]) awaited_results.push_back(op_results[k]);
      end
      sent_count++;
   endtask

   task automatic send_op(input mode_type m, input logic signed [31:0] v);
      send_request(m, v, 1'b0, ST_OK, '0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic mode_type random_insert();
      return $urandom_range(0, 1) ? MODE_INS_BACK : MODE_INS_FRONT;
   endfunction

   // Fills the list to capacity, pushes against the full list, lists it and
   // deletes the dominant value. With a single value the delete removes every entry the flood added.
   task automatic run_flood(input logic single_value);
      logic signed [31:0] main_value;
      logic signed [31:0] other_value;
      main_value  = $urandom;
      other_value = $urandom;
      while (model_len < CAPACITY) begin
         send_op(random_insert(),
                 (single_value || $urandom_range(0, 2) != 0) ? main_value : other_value);
      end
      repeat ($urandom_range(1, 2)) send_op(random_insert(), $urandom);
      send_op(MODE_LIST, $urandom);
      send_op(MODE_DELETE, main_value);
   endtask

   // A burst of mixed requests drawn from a small set of values so deletes hit.
   task automatic run_mix();
      logic signed [31:0] pool [3];
      logic signed [31:0] v;
      int r;
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(0, 11))
            0:       pool[k] = 32'sh7FFF_FFFF;
            1:       pool[k] = 32'sh8000_0000;
            2:       pool[k] = 32'sh0000_0000;
            3:       pool[k] = 32'shFFFF_FFFF;
            default: pool[k] = $urandom;
         endcase
      end
      repeat ($urandom_range(8, 30)) begin
         r = $urandom_range(0, 99);
         v = ($urandom_range(0, 9) == 0) ? 32'($urandom) : pool[$urandom_range(0, 2)];
         if (r < 50) begin
            send_op(random_insert(), v);
         end else if (r < 75) begin
            send_op(MODE_DELETE, v);
         end else begin
            send_op(MODE_LIST, v);
         end
      end
   endtask

   always @(negedge clock) begin
      int pct;
      pct = (idle_phase == IDLE_RECEIVER) ? 64 : (idle_phase == IDLE_BOTH) ? 26 : 0;
      rsp_stall <= !reset && ($urandom_range(0, 99) < pct);
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: item=%0d last=%0b removed=%0d status=%0d",
                        rsp_item_value, rsp_is_last, rsp_removed_count, rsp_status);
            end
         end else begin
            want = awaited_results.pop_front();
            if (rsp_item_value !== want.item || rsp_is_last !== want.last ||
                rsp_removed_count !== want.removed || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected item=%0d last=%0b removed=%0d status=%0d",
                           want.item, want.last, want.removed, want.status);
                  $display("          actual   item=%0d last=%0b removed=%0d status=%0d",
                           rsp_item_value, rsp_is_last, rsp_removed_count, rsp_status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int phase_end;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         send_request(directed_rows[k].mode, directed_rows[k].value, directed_rows[k].typed,
                      directed_rows[k].status, directed_rows[k].removed);
      end
      drain_results();

      // Each idling phase opens with a full-list flood and ends with the sender pausing
      // until every awaited result has come back.
      for (int p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
         idle_phase = p;
         phase_end = sent_count + PHASE_ITEMS;
         run_flood(1'b1);
         while (sent_count < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               run_flood(1'b0);
            end else begin
               run_mix();
            end
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
